[hw/rtl/dftacc_pkg.sv]
`timescale 1ns / 1ps
// shared types, constants and defaults for the running dft accumulator
// no dependencies

package dftacc_pkg;

  localparam int DEF_NUM_CELLS  = 4096;
  localparam int DEF_NUM_FREQS  = 4;
  localparam int DEF_PHASE_BITS = 16;

  localparam int SMP_W = 24;
  localparam int ACC_W = 48;
  localparam int PH_W  = 16;   // phasor part, signed q1.15
  localparam int SW_W  = 41;   // sample times weight
  localparam int PR_W  = 57;   // sw times phasor part
  localparam int INC_W = 26;   // rounded increment

  localparam logic [11:0] SIN_C = 12'd2320;
  localparam logic [14:0] SIN_B = 15'd21024;
  localparam logic [15:0] SIN_A = 16'd51472;

  localparam logic REQ_ACC  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef struct packed {
    logic                    req_type;
    logic [11:0]             cell_index;
    logic [1:0]              freq_index;
    logic [15:0]             phase;
    logic signed [SMP_W-1:0] sample_x;
    logic signed [SMP_W-1:0] sample_y;
    logic signed [SMP_W-1:0] sample_z;
  } in_beat_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] acc_x_real;
    logic signed [ACC_W-1:0] acc_x_imag;
    logic signed [ACC_W-1:0] acc_y_real;
    logic signed [ACC_W-1:0] acc_y_imag;
    logic signed [ACC_W-1:0] acc_z_real;
    logic signed [ACC_W-1:0] acc_z_imag;
  } out_beat_t;

  // controls for the add stage of each lane
  typedef struct packed {
    logic we;    // memory write this cycle
    logic clr;   // clearing pass write of zero
    logic wr;    // accumulate beat
    logic fwd;   // take previous result instead of memory data
    logic rng;   // address in range
  } lane_ctl_t;

endpackage

[hw/rtl/dftacc_phasor.sv]
`timescale 1ns / 1ps
// phasor generator: exp(-j*2*pi*phase) in q1.15, five register stages
// depends on dftacc_pkg

module dftacc_phasor import dftacc_pkg::*; #(
  parameter int PHASE_BITS = DEF_PHASE_BITS
) (
  input  logic                   clk,
  input  logic [15:0]            phase,
  output logic signed [PH_W-1:0] re,
  output logic signed [PH_W-1:0] im
);

  localparam logic [31:0] PMASK = 32'((64'd1 << PHASE_BITS) - 64'd1);

  logic [31:0] p32;
  logic [15:0] u_in [2];

  assign p32     = (32'(phase) & PMASK) << (32 - PHASE_BITS);
  assign u_in[0] = {1'b0, p32[29:15]};
  assign u_in[1] = 16'd32768 - {1'b0, p32[29:15]};

  logic [1:0] q2_r, q3_r, q4_r, q5_r;

  logic [15:0] u2s_r [2];
  logic [16:0] sq_r  [2];
  logic [15:0] u3s_r [2];
  logic [16:0] sq3_r [2];
  logic [14:0] t1_r  [2];
  logic [15:0] u4s_r [2];
  logic [15:0] t3_r  [2];
  logic [14:0] s_r   [2];

  // two polynomial units: sin of z and sin of the complement
  for (genvar g = 0; g < 2; g++) begin : g_qsin
    logic [31:0] m1;
    logic [28:0] m2;
    logic [31:0] m3;
    logic [31:0] m4;
    logic [16:0] s_full;

    assign m1     = 32'(u_in[g]) * 32'(u_in[g]);
    assign m2     = 29'(SIN_C) * 29'(sq_r[g]);
    assign m3     = 32'(t1_r[g]) * 32'(sq3_r[g]);
    assign m4     = 32'(t3_r[g]) * 32'(u4s_r[g]);
    assign s_full = m4[31:15];

    always_ff @(posedge clk) begin
      sq_r[g]  <= m1[31:15];
      u2s_r[g] <= u_in[g];
      t1_r[g]  <= SIN_B - 15'(m2[28:15]);
      sq3_r[g] <= sq_r[g];
      u3s_r[g] <= u2s_r[g];
      t3_r[g]  <= SIN_A - 16'(m3[31:15]);
      u4s_r[g] <= u3s_r[g];
      s_r[g]   <= (s_full > 17'd32767) ? 15'h7fff : s_full[14:0];
    end
  end

  logic signed [PH_W-1:0] sz, sc, re_nxt, im_nxt;

  assign sz = PH_W'(s_r[0]);
  assign sc = PH_W'(s_r[1]);

  always_comb begin
    unique case (q5_r)
      2'd0: begin re_nxt = sc;  im_nxt = -sz; end
      2'd1: begin re_nxt = -sz; im_nxt = -sc; end
      2'd2: begin re_nxt = -sc; im_nxt = sz;  end
      default: begin re_nxt = sz; im_nxt = sc; end
    endcase
  end

  always_ff @(posedge clk) begin
    q2_r <= p32[31:30];
    q3_r <= q2_r;
    q4_r <= q3_r;
    q5_r <= q4_r;
    re   <= re_nxt;
    im   <= im_nxt;
  end

endmodule

[hw/rtl/dftacc_lane.sv]
`timescale 1ns / 1ps
// one field component: weighting, phasor products, rounding and the
// saturating accumulator memory; depends on dftacc_pkg

module dftacc_lane import dftacc_pkg::*; #(
  parameter int DEPTH  = DEF_NUM_CELLS * DEF_NUM_FREQS,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                    clk,
  input  logic signed [SMP_W-1:0] sample,
  input  logic [15:0]             weight,
  input  logic signed [PH_W-1:0]  re,
  input  logic signed [PH_W-1:0]  im,
  input  logic [ADDR_W-1:0]       rd_addr,
  input  logic [ADDR_W-1:0]       wr_addr,
  input  lane_ctl_t               ctl,
  output logic signed [ACC_W-1:0] res_re,
  output logic signed [ACC_W-1:0] res_im
);

  logic [2*ACC_W-1:0] mem [DEPTH];
  logic [2*ACC_W-1:0] rd_q;

  logic signed [SW_W-1:0] sw_r [5];
  logic signed [PR_W-1:0] pre_r, pim_r;
  logic signed [INC_W-1:0] ire_r, iim_r;

  logic signed [PR_W-1:0] rre, rim;
  assign rre = pre_r + PR_W'(64'sd1073741824);
  assign rim = pim_r + PR_W'(64'sd1073741824);

  // weighted sample is delayed to meet the phasor at stage 6
  always_ff @(posedge clk) begin
    sw_r[0] <= SW_W'(sample) * SW_W'($signed({1'b0, weight}));
    sw_r[1] <= sw_r[0];
    sw_r[2] <= sw_r[1];
    sw_r[3] <= sw_r[2];
    sw_r[4] <= sw_r[3];
    pre_r   <= PR_W'(sw_r[4]) * PR_W'(re);
    pim_r   <= PR_W'(sw_r[4]) * PR_W'(im);
    ire_r   <= rre[PR_W-1:31];
    iim_r   <= rim[PR_W-1:31];
  end

  // add stage
  logic signed [ACC_W-1:0] old_re, old_im, sat_re, sat_im;
  logic signed [ACC_W:0]   sum_re, sum_im;
  logic signed [INC_W-1:0] add_re, add_im;

  assign old_re = ctl.fwd ? res_re : rd_q[2*ACC_W-1:ACC_W];
  assign old_im = ctl.fwd ? res_im : rd_q[ACC_W-1:0];
  assign add_re = ctl.wr ? ire_r : '0;
  assign add_im = ctl.wr ? iim_r : '0;
  assign sum_re = (ACC_W+1)'(old_re) + (ACC_W+1)'(add_re);
  assign sum_im = (ACC_W+1)'(old_im) + (ACC_W+1)'(add_im);

  always_comb begin
    if (sum_re[ACC_W] != sum_re[ACC_W-1]) begin
      sat_re = {sum_re[ACC_W], {(ACC_W-1){~sum_re[ACC_W]}}};
    end else begin
      sat_re = sum_re[ACC_W-1:0];
    end
    if (sum_im[ACC_W] != sum_im[ACC_W-1]) begin
      sat_im = {sum_im[ACC_W], {(ACC_W-1){~sum_im[ACC_W]}}};
    end else begin
      sat_im = sum_im[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[wr_addr] <= ctl.clr ? '0 : {sat_re, sat_im};
    end
    rd_q   <= mem[rd_addr];
    res_re <= ctl.rng ? sat_re : '0;
    res_im <= ctl.rng ? sat_im : '0;
  end

endmodule

[hw/rtl/running_dft_field_accumulator_top.sv]
`timescale 1ns / 1ps
// running dft accumulator: one result beat per accepted beat
// throughput one beat per clock while in_ready is high; back-to-back updates
// of one address are kept correct by forwarding; after reset a clearing pass
// zeroes every memory address, in_ready low meanwhile; step_weight resets to zero
// results queue in a 16-entry fifo, credit stops input at 16 beats in flight

module running_dft_field_accumulator_top import dftacc_pkg::*; #(
  parameter int NUM_CELLS  = DEF_NUM_CELLS,
  parameter int NUM_FREQS  = DEF_NUM_FREQS,
  parameter int PHASE_BITS = DEF_PHASE_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data,
  input  logic      cfg_we,
  input  logic [15:0] cfg_wdata
);

  localparam int DEPTH  = NUM_CELLS * NUM_FREQS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NST    = 9;    // pipeline stages, accept to result register
  localparam int FD     = 16;   // result fifo depth, above pipeline depth
  localparam int FP_W   = $clog2(FD);

  // configuration register
  logic [15:0] step_weight_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_weight_r <= '0;
    end else if (cfg_we) begin
      step_weight_r <= cfg_wdata;
    end
  end

  // clearing pass after reset
  logic              clr_busy_r;
  logic [ADDR_W-1:0] clr_cnt_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == ADDR_W'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // credit: beats in the pipeline plus beats waiting in the fifo
  logic [FP_W:0] cred_r;
  logic          in_acc, out_acc;

  assign in_ready = !clr_busy_r && (cred_r < (FP_W+1)'(FD));
  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cred_r <= '0;
    end else begin
      cred_r <= cred_r + (FP_W+1)'(in_acc) - (FP_W+1)'(out_acc);
    end
  end

  // address decode at the input
  logic              rng_in;
  logic [ADDR_W-1:0] addr_in;
  assign rng_in  = (32'(in_data.cell_index) < 32'(NUM_CELLS)) &&
                   (32'(in_data.freq_index) < 32'(NUM_FREQS));
  assign addr_in = ADDR_W'(32'(in_data.freq_index) * 32'(NUM_CELLS) +
                           32'(in_data.cell_index));

  // pipeline control, stage 1 is the input register
  logic              v_r    [1:NST];
  logic              rng_r  [1:NST];
  logic              wr_r   [1:NST];
  logic [ADDR_W-1:0] addr_r [1:NST];
  in_beat_t          beat1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= NST; i++) begin
        v_r[i]   <= 1'b0;
        rng_r[i] <= 1'b0;
        wr_r[i]  <= 1'b0;
      end
    end else begin
      v_r[1]   <= in_acc;
      rng_r[1] <= in_acc && rng_in;
      wr_r[1]  <= in_acc && rng_in && (in_data.req_type == REQ_ACC);
      for (int i = 2; i <= NST; i++) begin
        v_r[i]   <= v_r[i-1];
        rng_r[i] <= rng_r[i-1];
        wr_r[i]  <= wr_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      beat1_r <= in_data;
    end
    addr_r[1] <= addr_in;
    for (int i = 2; i <= NST; i++) begin
      addr_r[i] <= addr_r[i-1];
    end
  end

  // shared phasor, ready at stage 6
  logic signed [PH_W-1:0] ph_re, ph_im;

  dftacc_phasor #(.PHASE_BITS(PHASE_BITS)) u_phasor (
    .clk   (clk),
    .phase (beat1_r.phase),
    .re    (ph_re),
    .im    (ph_im)
  );

  // add-stage controls: the memory read is issued at stage 7, add at stage 8;
  // the stage-9 beat, if it wrote the same address, is forwarded from its result register
  lane_ctl_t         ctl;
  logic [ADDR_W-1:0] wr_addr;

  assign ctl.clr = clr_busy_r;
  assign ctl.wr  = v_r[8] && wr_r[8];
  assign ctl.we  = clr_busy_r || (v_r[8] && wr_r[8]);
  assign ctl.fwd = v_r[9] && wr_r[9] && (addr_r[9] == addr_r[8]);
  assign ctl.rng = rng_r[8];
  assign wr_addr = clr_busy_r ? clr_cnt_r : addr_r[8];

  // three lanes, one per field component
  logic signed [SMP_W-1:0] smp [3];
  logic signed [ACC_W-1:0] res_re [3];
  logic signed [ACC_W-1:0] res_im [3];

  assign smp[0] = beat1_r.sample_x;
  assign smp[1] = beat1_r.sample_y;
  assign smp[2] = beat1_r.sample_z;

  for (genvar k = 0; k < 3; k++) begin : g_lane
    dftacc_lane #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_lane (
      .clk     (clk),
      .sample  (smp[k]),
      .weight  (step_weight_r),
      .re      (ph_re),
      .im      (ph_im),
      .rd_addr (addr_r[7]),
      .wr_addr (wr_addr),
      .ctl     (ctl),
      .res_re  (res_re[k]),
      .res_im  (res_im[k])
    );
  end

  // merge lane results into one beat and queue it
  out_beat_t res_beat;
  assign res_beat.acc_x_real = res_re[0];
  assign res_beat.acc_x_imag = res_im[0];
  assign res_beat.acc_y_real = res_re[1];
  assign res_beat.acc_y_imag = res_im[1];
  assign res_beat.acc_z_real = res_re[2];
  assign res_beat.acc_z_imag = res_im[2];

  out_beat_t       fifo_r [FD];
  logic [FP_W-1:0] wp_r, rp_r;
  logic [FP_W:0]   fcnt_r;
  logic            push;

  assign push      = v_r[NST];
  assign out_valid = (fcnt_r != '0);
  assign out_data  = fifo_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      fcnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (out_acc) begin
        rp_r <= rp_r + 1'b1;
      end
      fcnt_r <= fcnt_r + (FP_W+1)'(push) - (FP_W+1)'(out_acc);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wp_r] <= res_beat;
    end
  end

  // checks
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !in_ready) else $error("beat accepted during clearing pass");

  a_fifo_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (fcnt_r < (FP_W+1)'(FD)) || out_acc) else $error("result fifo overflow");

  a_credit_covers_fifo: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= cred_r) else $error("fifo holds more than the credit count");

  a_no_write_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !(v_r[8] && wr_r[8])) else $error("accumulate during clearing pass");

endmodule
